/* rtl/nfha_pkg.sv */
// shared types and constants for the next-fit heap allocator
package nfha_pkg;

	// operation codes of an input transfer
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// status codes of a result transfer
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_ZERO = 2'd1;
	localparam logic [1:0] STATUS_OOM  = 2'd2;

	// heap layout constants in bytes
	localparam int WORD_BYTES  = 4;
	localparam int DWORD_BYTES = 8;
	localparam int MIN_BLOCK   = 2 * DWORD_BYTES;
	localparam int LIST_START  = 8;
	localparam int LIMIT_RESET = 1048576;

	// operation of the shared arithmetic unit
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

/* rtl/nfha_alu.sv */
// shared add and subtract unit used by the arithmetic steps of the sequencer
module nfha_alu #(
	parameter int W = 23
) (
	input  nfha_pkg::alu_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      y
);

	// one adder, subtract by two's complement of b
	always_comb begin
		case (op)
			nfha_pkg::ALU_ADD: y = a + b;
			nfha_pkg::ALU_SUB: y = a - b;
			default:           y = a + b;
		endcase
	end

endmodule

/* rtl/nfha_tag_ram.sv */
// boundary tag memory, one write and one registered read per cycle
module nfha_tag_ram #(
	parameter int DEPTH = 262144,
	parameter int IW    = 18,
	parameter int TW    = 21
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [TW-1:0] wdata,
	input  logic [IW-1:0] raddr,
	output logic [TW-1:0] rdata
);

	logic [TW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/next_fit_heap_allocator.sv */
// next-fit boundary-tag heap allocator, sequencer around a tag memory and a shared adder
// allocate: take and size the request, visit blocks in the next-fit search, then place the
//   block or split it; when no block fits, grow the heap and merge first
// free: walk blocks from the list start, then clear the block and merge
// one item at a time; the tag memory's one registered read per cycle and the shared adder
//   set the pace, the next item is taken the cycle after its result is loaded
// reset: tag writes lay out prologue, first chunk and epilogue
module next_fit_heap_allocator #(
	parameter int HEAP_BYTES  = 1048576,
	parameter int CHUNK_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [20:0] request_bytes,
	input  logic [19:0] block_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] result_address,
	output logic [1:0]  status,
	input  logic        cfg_wr_en,
	input  logic [20:0] cfg_wr_data
);

	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int IW    = $clog2(HEAP_BYTES) - 2;
	localparam int TW    = $clog2(HEAP_BYTES) + 1;
	localparam int W     = ($clog2(HEAP_BYTES) + 2 > 23) ? $clog2(HEAP_BYTES) + 2 : 23;
	localparam int CWORDS = CHUNK_BYTES / 4;
	localparam int CS     = ((CWORDS % 2) != 0 ? CWORDS + 1 : CWORDS) * 4;
	localparam int EFF0   = (HEAP_BYTES < nfha_pkg::LIMIT_RESET) ? HEAP_BYTES
		: nfha_pkg::LIMIT_RESET;
	localparam bit CHUNK_OK = (16 + CS <= EFF0) && (CS != 0);
	localparam int HEAP_END0 = CHUNK_OK ? 16 + CS : 16;
	localparam logic [IW-1:0] FOOT_IDX = IW'((16 + CS - 8) / 4);
	localparam logic [IW-1:0] EPI_IDX  = IW'((16 + CS - 4) / 4);
	localparam logic [2:0]    INIT_LAST = CHUNK_OK ? 3'd4 : 3'd2;

	typedef enum logic [22:0] {
		ST_IDLE = 23'h000001,
		ST_INIT = 23'h000002,
		ST_CALC = 23'h000004,
		ST_SRD  = 23'h000008,
		ST_SCHK = 23'h000010,
		ST_G0   = 23'h000020,
		ST_G1   = 23'h000040,
		ST_G2   = 23'h000080,
		ST_P0   = 23'h000100,
		ST_P1   = 23'h000200,
		ST_STH  = 23'h000400,
		ST_STF  = 23'h000800,
		ST_M0   = 23'h001000,
		ST_M1   = 23'h002000,
		ST_M2   = 23'h004000,
		ST_M3   = 23'h008000,
		ST_M4   = 23'h010000,
		ST_M5   = 23'h020000,
		ST_M6   = 23'h040000,
		ST_M7   = 23'h080000,
		ST_FRD  = 23'h100000,
		ST_FCHK = 23'h200000,
		ST_DONE = 23'h400000
	} state_t;

	state_t         state_q;
	state_t         st_ret_q;
	logic [2:0]     init_cnt_q;
	logic [20:0]    limit_q;
	logic [W-1:0]   heap_end_q;
	logic [W-1:0]   rover_q;
	logic           op_q;
	logic [20:0]    req_q;
	logic [19:0]    addr_q;
	logic [W-1:0]   asize_q;
	logic [W-1:0]   bp_q;
	logic [W-1:0]   s_q;
	logic [W-1:0]   nx_q;
	logic [W-1:0]   psize_q;
	logic [W-1:0]   nsize_q;
	logic [W-1:0]   rem_q;
	logic           pa_q;
	logic           na_q;
	logic           phase_q;
	logic [W-1:0]   st_bp_q;
	logic [W-1:0]   st_size_q;
	logic           st_a_q;
	logic [19:0]    res_q;
	logic [1:0]     stat_q;
	logic           out_valid_q;
	logic [19:0]    out_addr_q;
	logic [1:0]     out_stat_q;

	nfha_pkg::alu_op_t alu_op;
	logic [W-1:0]      alu_a;
	logic [W-1:0]      alu_b;
	logic [W-1:0]      alu_y;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [TW-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic [TW-1:0] mem_rdata;

	logic [W-1:0]  rd_size;
	logic          rd_alloc;
	logic [W-1:0]  grow_size;
	logic          search_cont;
	logic          out_free;

	function automatic logic [IW-1:0] widx(input logic [W-1:0] a);
		widx = a[IW+1:2];
	endfunction

	// fields of the tag word just read
	assign rd_size  = W'({mem_rdata[TW-1:3], 3'b000});
	assign rd_alloc = mem_rdata[0];

	// growth step: the block size when above a chunk, else one rounded chunk
	assign grow_size = (asize_q > W'(CHUNK_BYTES)) ? asize_q : W'(CS);

	// next-fit search continues while the block lies before the end (and the rover)
	assign search_cont = (bp_q < heap_end_q) && (!phase_q || (bp_q != rover_q));

	assign out_free = !out_valid_q || !out_stall;

	nfha_alu #(
		.W(W)
	) u_alu (
		.op(alu_op),
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	nfha_tag_ram #(
		.DEPTH(DEPTH),
		.IW   (IW),
		.TW   (TW)
	) u_tag_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// operand selection for the shared adder
	always_comb begin
		alu_op = nfha_pkg::ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			ST_CALC: begin
				alu_a = W'(req_q);
				alu_b = W'(15);
			end
			ST_SCHK, ST_M2, ST_FCHK: begin
				alu_a = bp_q;
				alu_b = rd_size;
			end
			ST_G0: begin
				alu_a = heap_end_q;
				alu_b = grow_size;
			end
			ST_STH: begin
				alu_a = st_bp_q;
				alu_b = st_size_q;
			end
			ST_M5: begin
				alu_a = s_q;
				alu_b = nsize_q;
			end
			ST_M6: begin
				alu_a = s_q;
				alu_b = psize_q;
			end
			ST_M7: begin
				alu_op = nfha_pkg::ALU_SUB;
				alu_a  = bp_q;
				alu_b  = psize_q;
			end
			ST_P0: begin
				alu_op = nfha_pkg::ALU_SUB;
				alu_a  = s_q;
				alu_b  = asize_q;
			end
			ST_P1: begin
				alu_a = bp_q;
				alu_b = asize_q;
			end
			default: begin
				alu_op = nfha_pkg::ALU_ADD;
			end
		endcase
	end

	// tag memory access per step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				case (init_cnt_q)
					3'd0: begin
						mem_waddr = IW'(1);
						mem_wdata = TW'(9);
					end
					3'd1: begin
						mem_waddr = IW'(2);
						mem_wdata = TW'(9);
					end
					3'd2: begin
						mem_waddr = IW'(3);
						mem_wdata = CHUNK_OK ? TW'(CS) : TW'(1);
					end
					3'd3: begin
						mem_waddr = FOOT_IDX;
						mem_wdata = TW'(CS);
					end
					default: begin
						mem_waddr = EPI_IDX;
						mem_wdata = TW'(1);
					end
				endcase
			end
			ST_STH: begin
				mem_we    = 1'b1;
				mem_waddr = widx(st_bp_q) - IW'(1);
				mem_wdata = st_size_q[TW-1:0] | TW'(st_a_q);
			end
			ST_STF: begin
				mem_we    = 1'b1;
				mem_waddr = widx(nx_q) - IW'(2);
				mem_wdata = st_size_q[TW-1:0] | TW'(st_a_q);
			end
			ST_G2: begin
				mem_we    = 1'b1;
				mem_waddr = widx(nx_q) - IW'(1);
				mem_wdata = TW'(1);
			end
			ST_SRD, ST_M1, ST_FRD: begin
				mem_raddr = widx(bp_q) - IW'(1);
			end
			ST_M0: begin
				mem_raddr = widx(bp_q) - IW'(2);
			end
			ST_M3: begin
				mem_raddr = widx(nx_q) - IW'(1);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 21'(nfha_pkg::LIMIT_RESET);
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// sequencer and heap state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			st_ret_q   <= ST_IDLE;
			init_cnt_q <= '0;
			heap_end_q <= W'(HEAP_END0);
			rover_q    <= W'(nfha_pkg::LIST_START);
			phase_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + 3'd1;
					if (init_cnt_q == INIT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q   <= operation;
						req_q  <= request_bytes;
						addr_q <= block_address;
						res_q  <= '0;
						stat_q <= nfha_pkg::STATUS_OK;
						if (operation == nfha_pkg::OP_FREE) begin
							bp_q    <= W'(nfha_pkg::LIST_START);
							state_q <= ST_FRD;
						end else if (request_bytes == '0) begin
							stat_q  <= nfha_pkg::STATUS_ZERO;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					asize_q <= (req_q <= 21'(nfha_pkg::DWORD_BYTES))
						? W'(nfha_pkg::MIN_BLOCK) : {alu_y[W-1:3], 3'b000};
					bp_q    <= rover_q;
					phase_q <= 1'b0;
					state_q <= ST_SRD;
				end
				ST_SRD: begin
					if (search_cont) begin
						state_q <= ST_SCHK;
					end else if (!phase_q) begin
						bp_q    <= W'(nfha_pkg::LIST_START);
						phase_q <= 1'b1;
					end else begin
						state_q <= ST_G0;
					end
				end
				ST_SCHK: begin
					if (rd_size == '0) begin
						if (!phase_q) begin
							bp_q    <= W'(nfha_pkg::LIST_START);
							phase_q <= 1'b1;
							state_q <= ST_SRD;
						end else begin
							state_q <= ST_G0;
						end
					end else if (!rd_alloc && (asize_q <= rd_size)) begin
						s_q     <= rd_size;
						state_q <= ST_P0;
					end else begin
						bp_q    <= alu_y;
						state_q <= ST_SRD;
					end
				end
				// grow: check the limit, then lay out the new block and epilogue
				ST_G0: begin
					s_q     <= grow_size;
					nx_q    <= alu_y;
					state_q <= ST_G1;
				end
				ST_G1: begin
					if ((nx_q > W'(limit_q)) || (nx_q > W'(HEAP_BYTES))) begin
						stat_q  <= nfha_pkg::STATUS_OOM;
						state_q <= ST_DONE;
					end else begin
						bp_q      <= heap_end_q;
						st_bp_q   <= heap_end_q;
						st_size_q <= s_q;
						st_a_q    <= 1'b0;
						st_ret_q  <= ST_G2;
						state_q   <= ST_STH;
					end
				end
				ST_G2: begin
					heap_end_q <= nx_q;
					state_q    <= ST_M0;
				end
				// header and footer write pair
				ST_STH: begin
					nx_q    <= alu_y;
					state_q <= ST_STF;
				end
				ST_STF: begin
					state_q <= st_ret_q;
				end
				// merge with free neighbours
				ST_M0: begin
					state_q <= ST_M1;
				end
				ST_M1: begin
					psize_q <= rd_size;
					pa_q    <= rd_alloc;
					state_q <= ST_M2;
				end
				ST_M2: begin
					s_q     <= rd_size;
					nx_q    <= alu_y;
					state_q <= ST_M3;
				end
				ST_M3: begin
					state_q <= ST_M4;
				end
				ST_M4: begin
					nsize_q <= rd_size;
					na_q    <= rd_alloc;
					if (pa_q && rd_alloc) begin
						state_q <= (op_q == nfha_pkg::OP_FREE) ? ST_DONE : ST_P0;
					end else begin
						state_q <= ST_M5;
					end
				end
				ST_M5: begin
					if (!na_q) begin
						s_q <= alu_y;
					end
					state_q <= ST_M6;
				end
				ST_M6: begin
					if (!pa_q) begin
						s_q <= alu_y;
					end
					state_q <= ST_M7;
				end
				ST_M7: begin
					if (!pa_q) begin
						bp_q    <= alu_y;
						st_bp_q <= alu_y;
						rover_q <= alu_y;
					end else begin
						st_bp_q <= bp_q;
						rover_q <= bp_q;
					end
					st_size_q <= s_q;
					st_a_q    <= 1'b0;
					st_ret_q  <= (op_q == nfha_pkg::OP_FREE) ? ST_DONE : ST_P0;
					state_q   <= ST_STH;
				end
				// place the block, splitting off a free remainder when large enough
				ST_P0: begin
					res_q  <= bp_q[19:0];
					st_bp_q <= bp_q;
					st_a_q  <= 1'b1;
					rem_q   <= alu_y;
					if (alu_y >= W'(nfha_pkg::MIN_BLOCK)) begin
						st_size_q <= asize_q;
						st_ret_q  <= ST_P1;
					end else begin
						st_size_q <= s_q;
						st_ret_q  <= ST_DONE;
						rover_q   <= bp_q;
					end
					state_q <= ST_STH;
				end
				ST_P1: begin
					st_bp_q   <= alu_y;
					st_size_q <= rem_q;
					st_a_q    <= 1'b0;
					st_ret_q  <= ST_DONE;
					rover_q   <= alu_y;
					state_q   <= ST_STH;
				end
				// free: walk the list from its start to find the block
				ST_FRD: begin
					state_q <= (bp_q < heap_end_q) ? ST_FCHK : ST_DONE;
				end
				ST_FCHK: begin
					if ((rd_size == '0) || (bp_q > W'(addr_q))) begin
						state_q <= ST_DONE;
					end else if (bp_q == W'(addr_q)) begin
						if ((bp_q != W'(nfha_pkg::LIST_START)) && rd_alloc) begin
							st_bp_q   <= bp_q;
							st_size_q <= rd_size;
							st_a_q    <= 1'b0;
							st_ret_q  <= ST_M0;
							state_q   <= ST_STH;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						bp_q    <= alu_y;
						state_q <= ST_FRD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register, loaded when the result slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_addr_q <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_stat_q;

	// heap never grows past the tag memory
	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		heap_end_q <= W'(HEAP_BYTES))
		else $error("heap end beyond tag memory");

	// rover always points inside the heap
	a_rover_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(rover_q < heap_end_q) && (rover_q[2:0] == 3'b000))
		else $error("rover outside heap or misaligned");

	// search runs only with an aligned block size of at least the minimum
	a_asize_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRD) |-> ((asize_q[2:0] == 3'b000)
			&& (asize_q >= W'(nfha_pkg::MIN_BLOCK))))
		else $error("bad rounded block size");

	// a result is loaded only after an accepted item
	a_result_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result without an item");

endmodule

/* bench/testbench.sv */
// self-checking testbench for the next-fit heap allocator
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_SIZE   = 1048576;
	localparam int CHUNK_SIZE  = 8192;
	localparam int TAG_DEPTH   = HEAP_SIZE / nfha_pkg::WORD_BYTES;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int RAND_ITEMS  = 170;

	typedef struct {
		logic        op;
		logic [20:0] req;
		logic [19:0] addr;
	} heap_req_t;

	typedef struct {
		logic [19:0] addr;
		logic [1:0]  st;
	} heap_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = nfha_pkg::OP_ALLOC;
	logic [20:0] request_bytes = '0;
	logic [19:0] block_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [19:0] result_address;
	logic [1:0]  status;
	logic        cfg_wr_en = 1'b0;
	logic [20:0] cfg_wr_data = '0;

	// shadow heap state
	int unsigned tags [0:TAG_DEPTH-1];
	int unsigned top_of_heap, next_fit_ptr, limit_reg;
	int unsigned live_blocks[$];

	heap_req_t  pending[$];
	heap_resp_t awaited[$];
	heap_req_t  cur;
	int unsigned send_idle_pct = 0, recv_stall_pct = 0;
	logic        hold_start = 1'b0;
	int unsigned hold_left = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	next_fit_heap_allocator #(.HEAP_BYTES(HEAP_SIZE), .CHUNK_BYTES(CHUNK_SIZE)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .request_bytes(request_bytes), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_address(result_address), .status(status),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned tag_get(int unsigned a);
		int unsigned i;
		i = a >> 2;
		return (i < TAG_DEPTH) ? tags[i] : 0;
	endfunction

	function automatic void tag_put(int unsigned a, int unsigned v);
		int unsigned i;
		i = a >> 2;
		if (i < TAG_DEPTH)
			tags[i] = v;
	endfunction

	function automatic int unsigned size_of(int unsigned bp);
		return tag_get(bp - nfha_pkg::WORD_BYTES) & ~32'h7;
	endfunction

	function automatic int unsigned used_of(int unsigned bp);
		return tag_get(bp - nfha_pkg::WORD_BYTES) & 1;
	endfunction

	function automatic void write_tags(int unsigned bp, int unsigned sz, int unsigned a);
		tag_put(bp - nfha_pkg::WORD_BYTES, sz | a);
		tag_put(bp + sz - nfha_pkg::DWORD_BYTES, sz | a);
	endfunction

	// coalesce a free block with free neighbors
	function automatic int unsigned coalesce(int unsigned bp);
		int unsigned psz, prv, sz, nxt, pa, na;
		psz = tag_get(bp - nfha_pkg::DWORD_BYTES) & ~32'h7;
		prv = bp - psz;
		sz  = size_of(bp);
		nxt = bp + sz;
		pa  = tag_get(bp - nfha_pkg::DWORD_BYTES) & 1;
		na  = used_of(nxt);
		if (pa && na)
			return bp;
		if (pa) begin
			sz += size_of(nxt);
			write_tags(bp, sz, 0);
		end else if (na) begin
			sz += psz;
			write_tags(prv, sz, 0);
			bp = prv;
		end else begin
			sz += psz + size_of(nxt);
			write_tags(prv, sz, 0);
			bp = prv;
		end
		next_fit_ptr = bp;
		return bp;
	endfunction

	function automatic int unsigned grow_heap(int unsigned bytes);
		int unsigned w, sz, bp, lim;
		w   = bytes / nfha_pkg::WORD_BYTES;
		sz  = ((w & 1) ? w + 1 : w) * nfha_pkg::WORD_BYTES;
		bp  = top_of_heap;
		lim = (limit_reg > HEAP_SIZE) ? HEAP_SIZE : limit_reg;
		if (sz == 0 || top_of_heap + sz > lim)
			return 0;
		write_tags(bp, sz, 0);
		tag_put(bp + sz - nfha_pkg::WORD_BYTES, 1);
		top_of_heap += sz;
		return coalesce(bp);
	endfunction

	function automatic int unsigned next_fit_search(int unsigned asz);
		int unsigned bp, s;
		for (bp = next_fit_ptr; bp < top_of_heap; bp += s) begin
			s = size_of(bp);
			if (s == 0)
				break;
			if (!used_of(bp) && asz <= s)
				return bp;
		end
		for (bp = nfha_pkg::LIST_START; bp != next_fit_ptr && bp < top_of_heap; bp += s) begin
			s = size_of(bp);
			if (s == 0)
				break;
			if (!used_of(bp) && asz <= s)
				return bp;
		end
		return 0;
	endfunction

	function automatic bit is_live_block(int unsigned a);
		int unsigned bp, s;
		for (bp = nfha_pkg::LIST_START; bp < top_of_heap; bp += s) begin
			s = size_of(bp);
			if (s == 0 || bp > a)
				return 0;
			if (bp == a)
				return bp != nfha_pkg::LIST_START && used_of(bp) != 0;
		end
		return 0;
	endfunction

	function automatic void heap_reset();
		int unsigned dummy;
		foreach (tags[i])
			tags[i] = 0;
		limit_reg = nfha_pkg::LIMIT_RESET;
		tag_put(4, nfha_pkg::DWORD_BYTES | 1);
		tag_put(8, nfha_pkg::DWORD_BYTES | 1);
		tag_put(12, 1);
		top_of_heap = 16;
		next_fit_ptr = nfha_pkg::LIST_START;
		dummy = grow_heap(CHUNK_SIZE);
	endfunction

	// expected response of one accepted request, updating the shadow heap
	function automatic heap_resp_t serve_request(heap_req_t r);
		heap_resp_t rsp;
		int unsigned asz, bp, ext, csz, dummy;
		rsp.addr = '0;
		rsp.st = nfha_pkg::STATUS_OK;
		if (r.op == nfha_pkg::OP_FREE) begin
			if (is_live_block(r.addr)) begin
				write_tags(r.addr, size_of(r.addr), 0);
				dummy = coalesce(r.addr);
				foreach (live_blocks[i])
					if (live_blocks[i] == r.addr) begin
						live_blocks.delete(i);
						break;
					end
			end
		end else if (r.req == 0) begin
			rsp.st = nfha_pkg::STATUS_ZERO;
		end else begin
			asz = (r.req <= nfha_pkg::DWORD_BYTES) ? nfha_pkg::MIN_BLOCK
				: ((r.req + nfha_pkg::DWORD_BYTES + 7) & ~32'h7);
			bp = next_fit_search(asz);
			if (bp == 0) begin
				ext = (asz > CHUNK_SIZE) ? asz : CHUNK_SIZE;
				bp = grow_heap(ext);
			end
			if (bp == 0) begin
				rsp.st = nfha_pkg::STATUS_OOM;
			end else begin
				csz = size_of(bp);
				if (csz - asz >= nfha_pkg::MIN_BLOCK) begin
					write_tags(bp, asz, 1);
					write_tags(bp + asz, csz - asz, 0);
					next_fit_ptr = bp + asz;
				end else begin
					write_tags(bp, csz, 1);
					next_fit_ptr = bp;
				end
				rsp.addr = bp[19:0];
				live_blocks.push_back(bp);
			end
		end
		return rsp;
	endfunction

	// input driver
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			awaited.push_back(serve_request(cur));
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur = pending.pop_front();
				in_valid <= 1'b1;
				operation <= cur.op;
				request_bytes <= cur.req;
				block_address <= cur.addr;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off counter
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= 3000;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result monitor and checker
	always @(posedge clk) begin
		heap_resp_t exp_rsp;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: addr %0d status %0d",
						result_address, status);
			end else begin
				exp_rsp = awaited.pop_front();
				if (exp_rsp.addr !== result_address || exp_rsp.st !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
							exp_rsp.addr, exp_rsp.st, result_address, status);
				end
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_req(logic op, logic [20:0] req, logic [19:0] addr);
		heap_req_t r;
		r.op = op;
		r.req = req;
		r.addr = addr;
		while (pending.size() >= 4)
			@(posedge clk);
		pending.push_back(r);
	endtask

	task automatic settle();
		while (pending.size() != 0 || in_valid || awaited.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_limit(logic [20:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		limit_reg = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_random_req();
		int unsigned r, sz, a;
		r = $urandom_range(99);
		if (r < 58) begin
			sz = $urandom_range(99);
			if (sz < 3)
				add_req(nfha_pkg::OP_ALLOC, 21'd0, 20'($urandom));
			else if (sz < 5)
				add_req(nfha_pkg::OP_ALLOC, 21'($urandom), 20'($urandom));
			else if (sz < 8)
				add_req(nfha_pkg::OP_ALLOC, 21'($urandom_range(8193, 300000)), 20'($urandom));
			else if (sz < 20)
				add_req(nfha_pkg::OP_ALLOC, 21'($urandom_range(1, 8192)), 20'($urandom));
			else
				add_req(nfha_pkg::OP_ALLOC, 21'($urandom_range(1, 200)), 20'($urandom));
		end else if (r < 92 && live_blocks.size() != 0) begin
			a = live_blocks[$urandom_range(live_blocks.size() - 1)];
			add_req(nfha_pkg::OP_FREE, 21'($urandom), 20'(a));
		end else begin
			// broken frees: interior, prologue, anywhere
			sz = $urandom_range(2);
			if (sz == 0 && live_blocks.size() != 0)
				a = live_blocks[$urandom_range(live_blocks.size() - 1)] + 4;
			else if (sz == 1)
				a = nfha_pkg::LIST_START;
			else
				a = $urandom;
			add_req(nfha_pkg::OP_FREE, 21'($urandom), 20'(a));
		end
	endtask

	// stimulus
	initial begin
		heap_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sizes at the edges, growth, out of memory, invalid and merging frees
		add_req(nfha_pkg::OP_ALLOC, 21'd0, 20'hfffff);
		add_req(nfha_pkg::OP_ALLOC, 21'd1, 20'd0);
		add_req(nfha_pkg::OP_ALLOC, 21'd8, 20'd0);
		add_req(nfha_pkg::OP_ALLOC, 21'd9, 20'd0);
		add_req(nfha_pkg::OP_ALLOC, 21'd24, 20'd0);
		add_req(nfha_pkg::OP_ALLOC, 21'd8192, 20'd0);
		add_req(nfha_pkg::OP_ALLOC, 21'd1048576, 20'd0);
		add_req(nfha_pkg::OP_ALLOC, 21'h1fffff, 20'd0);
		add_req(nfha_pkg::OP_ALLOC, 21'd20000, 20'd0);
		add_req(nfha_pkg::OP_FREE, 21'h1fffff, 20'd8);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'd0);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'hfffff);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'd20);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'd32);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'd32);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'd16);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'd48);
		add_req(nfha_pkg::OP_ALLOC, 21'd40, 20'd0);
		add_req(nfha_pkg::OP_FREE, 21'd0, 20'd16);

		// phases with different limits and idling
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin set_limit(21'd1048576); send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin set_limit(21'd8208);    send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin set_limit(21'h1fffff);  send_idle_pct = 0;  recv_stall_pct = 80; end
				3: begin set_limit(21'd60000);   send_idle_pct = 38; recv_stall_pct = 38; end
				default: begin set_limit(21'd1048576); send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < RAND_ITEMS; n++) begin
				// one-cycle pulse that starts the long receiver hold-off
				if (ph == 0 && n == 40) begin
					hold_start <= 1'b1;
					@(posedge clk);
					hold_start <= 1'b0;
				end
				// sender pause until the block has answered everything
				if (ph == 4 && n == 80)
					settle();
				add_random_req();
			end
		end

		settle();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
